[rtl/sll_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sll_pkg: shared types and constants for the linked list engine
// Node pool geometry, command and status codes, channel structs, and the
// request bundle that drives the node pool memories.
// ----------------------------------------------------------------------------
package sll_pkg;

  localparam int NODES     = 256;
  localparam int DATA_BITS = 32;
  localparam int IDX_W     = $clog2(NODES + 1);
  localparam int ADDR_W    = $clog2(NODES);

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [DATA_BITS-1:0] word_t;

  // Null pointer: one past the last node
  localparam idx_t NIL = IDX_W'(NODES);

  localparam logic [3:0] OP_CLEAR     = 4'd0;
  localparam logic [3:0] OP_INS_HEAD  = 4'd1;
  localparam logic [3:0] OP_CUR_HEAD  = 4'd2;
  localparam logic [3:0] OP_READ_HEAD = 4'd3;
  localparam logic [3:0] OP_DEL_HEAD  = 4'd4;
  localparam logic [3:0] OP_DEL_AFTER = 4'd5;
  localparam logic [3:0] OP_INS_AFTER = 4'd6;
  localparam logic [3:0] OP_READ_CUR  = 4'd7;
  localparam logic [3:0] OP_WRITE_CUR = 4'd8;
  localparam logic [3:0] OP_ADVANCE   = 4'd9;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_NO_CURSOR = 2'd3;

  typedef struct packed {
    logic [3:0]         opcode;
    logic signed [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic               cursor_set;
    logic               list_empty;
  } rsp_t;

  typedef struct packed {
    logic  data_re;
    addr_t data_raddr;
    logic  data_we;
    addr_t data_waddr;
    word_t data_wdata;
    logic  link_re;
    addr_t link_raddr;
    logic  link_we;
    addr_t link_waddr;
    idx_t  link_wdata;
  } mem_req_t;

  function automatic logic is_node(idx_t i);
    return i < NIL;
  endfunction

  // Any index outside the pool reads as null
  function automatic idx_t norm(idx_t i);
    return (i < NIL) ? i : NIL;
  endfunction

  function automatic word_t to_word(logic signed [31:0] v);
    logic signed [63:0] w;
    w = v;
    return w[DATA_BITS-1:0];
  endfunction

  function automatic logic signed [31:0] to_read(word_t d);
    logic signed [DATA_BITS-1:0] s;
    logic signed [63:0]          w;
    s = d;
    w = s;
    return w[31:0];
  endfunction

endpackage

`default_nettype wire

[rtl/singly_linked_list_engine.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// singly_linked_list_engine: linked list with cursor in a fixed node pool
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd) carries one command per
//   transaction: opcode and a data word. rsp channel (rsp_valid / rsp_stall /
//   rsp) returns exactly one result per command, in order.
//   Commands run one at a time. The first memory read is issued in the cycle
//   the command is taken; a second read and the write-back follow. Most
//   commands load their result in the first write-back state (S_WB1);
//   delete after cursor and insert after cursor pass through a second one
//   (S_WB2) when they change two link entries, since both go through the
//   single link write port. cmd_stall is low again the cycle after the
//   result is loaded.
//   The result sits in an output register, so a new command is taken while
//   the previous result waits. If rsp_stall holds the output register full,
//   the next command stops at write-back until the result is taken.
//   Reset (rst, synchronous) empties the list, clears the cursor, the free
//   list and the fresh-node counter. No memory sweep is needed: node memory
//   is only used at entries that were written since the last clear.
// ----------------------------------------------------------------------------
module singly_linked_list_engine (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  output logic               cmd_stall,
  input  wire sll_pkg::cmd_t cmd,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output sll_pkg::rsp_t      rsp
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD2  = 4'b0010,
    S_WB1  = 4'b0100,
    S_WB2  = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [3:0]     op;
  sll_pkg::word_t val;
  sll_pkg::idx_t  t1;
  sll_pkg::idx_t  n_reg;
  sll_pkg::idx_t  head, head_next;
  sll_pkg::idx_t  cursor, cursor_next;
  sll_pkg::idx_t  free, free_next;
  sll_pkg::idx_t  fresh, fresh_next;

  sll_pkg::mem_req_t req;
  sll_pkg::word_t    data_rd;
  sll_pkg::idx_t     link_rd;

  logic               go;
  logic               load_out;
  logic               need2;
  logic               head_ok;
  logic               cursor_ok;
  logic signed [31:0] rd_res;
  logic [1:0]         st_res;

  // Node allocation: free list first, then fresh slots
  sll_pkg::idx_t take_link;
  sll_pkg::idx_t n_new;
  sll_pkg::idx_t free_after;
  sll_pkg::idx_t fresh_after;
  logic          n_ok;

  sll_pool u_pool (
    .clk     (clk),
    .req     (req),
    .data_rd (data_rd),
    .link_rd (link_rd)
  );

  assign cmd_stall = (state != S_IDLE);
  assign go        = !rsp_valid || !rsp_stall;
  assign head_ok   = sll_pkg::is_node(head);
  assign cursor_ok = sll_pkg::is_node(cursor);

  always_comb begin
    take_link   = (op == sll_pkg::OP_INS_AFTER) ? link_rd : t1;
    n_new       = sll_pkg::NIL;
    free_after  = free;
    fresh_after = fresh;
    n_ok        = 1'b0;
    if (sll_pkg::is_node(free)) begin
      n_new      = free;
      free_after = sll_pkg::norm(take_link);
      n_ok       = 1'b1;
    end else if (fresh < sll_pkg::NIL) begin
      n_new       = fresh;
      fresh_after = fresh + sll_pkg::idx_t'(1);
      n_ok        = 1'b1;
    end
  end

  always_comb begin
    req         = '0;
    state_next  = state;
    head_next   = head;
    cursor_next = cursor;
    free_next   = free;
    fresh_next  = fresh;
    rd_res      = '0;
    st_res      = sll_pkg::ST_OK;
    need2       = 1'b0;
    load_out    = 1'b0;

    unique case (state)
      S_IDLE: begin
        req.data_raddr = (cmd.opcode == sll_pkg::OP_READ_HEAD) ?
                         head[sll_pkg::ADDR_W-1:0] : cursor[sll_pkg::ADDR_W-1:0];
        if (cmd.opcode == sll_pkg::OP_INS_HEAD) begin
          req.link_raddr = free[sll_pkg::ADDR_W-1:0];
        end else if (cmd.opcode == sll_pkg::OP_DEL_HEAD) begin
          req.link_raddr = head[sll_pkg::ADDR_W-1:0];
        end else begin
          req.link_raddr = cursor[sll_pkg::ADDR_W-1:0];
        end
        if (cmd_valid) begin
          req.data_re = 1'b1;
          req.link_re = 1'b1;
          state_next  = S_RD2;
        end
      end

      S_RD2: begin
        // Second hop: the node after the victim, or the free list successor
        req.link_re    = 1'b1;
        req.link_raddr = (op == sll_pkg::OP_DEL_AFTER) ?
                         link_rd[sll_pkg::ADDR_W-1:0] : free[sll_pkg::ADDR_W-1:0];
        state_next     = S_WB1;
      end

      S_WB1: begin
        case (op)
          sll_pkg::OP_CLEAR: begin
            head_next   = sll_pkg::NIL;
            cursor_next = sll_pkg::NIL;
            free_next   = sll_pkg::NIL;
            fresh_next  = '0;
          end
          sll_pkg::OP_INS_HEAD: begin
            if (n_ok) begin
              req.data_we    = 1'b1;
              req.data_waddr = n_new[sll_pkg::ADDR_W-1:0];
              req.data_wdata = val;
              req.link_we    = 1'b1;
              req.link_waddr = n_new[sll_pkg::ADDR_W-1:0];
              req.link_wdata = head;
              head_next      = n_new;
              free_next      = free_after;
              fresh_next     = fresh_after;
            end else begin
              st_res = sll_pkg::ST_FULL;
            end
          end
          sll_pkg::OP_CUR_HEAD: begin
            cursor_next = head;
          end
          sll_pkg::OP_READ_HEAD: begin
            if (head_ok) begin
              rd_res = sll_pkg::to_read(data_rd);
            end else begin
              st_res = sll_pkg::ST_EMPTY;
            end
          end
          sll_pkg::OP_DEL_HEAD: begin
            if (head_ok) begin
              if (cursor == head) begin
                cursor_next = sll_pkg::NIL;
              end
              head_next      = sll_pkg::norm(t1);
              req.link_we    = 1'b1;
              req.link_waddr = head[sll_pkg::ADDR_W-1:0];
              req.link_wdata = free;
              free_next      = head;
            end
          end
          sll_pkg::OP_DEL_AFTER: begin
            // Release the victim now, relink the cursor node in S_WB2
            if (cursor_ok && sll_pkg::is_node(t1)) begin
              req.link_we    = 1'b1;
              req.link_waddr = t1[sll_pkg::ADDR_W-1:0];
              req.link_wdata = free;
              free_next      = t1;
              need2          = 1'b1;
            end
          end
          sll_pkg::OP_INS_AFTER: begin
            if (cursor_ok) begin
              if (n_ok) begin
                req.data_we    = 1'b1;
                req.data_waddr = n_new[sll_pkg::ADDR_W-1:0];
                req.data_wdata = val;
                req.link_we    = 1'b1;
                req.link_waddr = n_new[sll_pkg::ADDR_W-1:0];
                req.link_wdata = sll_pkg::norm(t1);
                free_next      = free_after;
                fresh_next     = fresh_after;
                need2          = 1'b1;
              end else begin
                st_res = sll_pkg::ST_FULL;
              end
            end
          end
          sll_pkg::OP_READ_CUR: begin
            if (cursor_ok) begin
              rd_res = sll_pkg::to_read(data_rd);
            end else begin
              st_res = sll_pkg::ST_NO_CURSOR;
            end
          end
          sll_pkg::OP_WRITE_CUR: begin
            if (cursor_ok) begin
              req.data_we    = 1'b1;
              req.data_waddr = cursor[sll_pkg::ADDR_W-1:0];
              req.data_wdata = val;
            end
          end
          sll_pkg::OP_ADVANCE: begin
            if (cursor_ok) begin
              cursor_next = sll_pkg::norm(t1);
            end
          end
          default: begin
          end
        endcase

        if (need2) begin
          state_next = S_WB2;
        end else if (go) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end else begin
          // Hold until the output register frees up
          req.data_we = 1'b0;
          req.link_we = 1'b0;
          head_next   = head;
          cursor_next = cursor;
          free_next   = free;
          fresh_next  = fresh;
        end
      end

      S_WB2: begin
        req.link_we    = go;
        req.link_waddr = cursor[sll_pkg::ADDR_W-1:0];
        req.link_wdata = (op == sll_pkg::OP_DEL_AFTER) ? sll_pkg::norm(link_rd) : n_reg;
        load_out       = go;
        if (go) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      head   <= sll_pkg::NIL;
      cursor <= sll_pkg::NIL;
      free   <= sll_pkg::NIL;
      fresh  <= '0;
    end else begin
      state  <= state_next;
      head   <= head_next;
      cursor <= cursor_next;
      free   <= free_next;
      fresh  <= fresh_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd_valid) begin
      op  <= cmd.opcode;
      val <= sll_pkg::to_word(cmd.value);
    end
    if (state == S_RD2) begin
      t1 <= link_rd;
    end
    if (state == S_WB1) begin
      n_reg <= n_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_out) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp.read_value <= rd_res;
      rsp.status     <= st_res;
      rsp.cursor_set <= sll_pkg::is_node(cursor_next);
      rsp.list_empty <= !sll_pkg::is_node(head_next);
    end
  end

`ifndef SYNTH
  a_cursor_in_list: assert property (@(posedge clk) disable iff (rst)
    !sll_pkg::is_node(head) |-> !sll_pkg::is_node(cursor))
    else $error("cursor set on an empty list");

  a_free_disjoint: assert property (@(posedge clk) disable iff (rst)
    sll_pkg::is_node(head) |-> free != head)
    else $error("head node also on the free list");

  a_fresh_bound: assert property (@(posedge clk) disable iff (rst)
    fresh <= sll_pkg::NIL)
    else $error("fresh-node counter past the pool");

  a_rsp_from_wb: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_WB1) || $past(state == S_WB2))
    else $error("result loaded outside write-back");
`endif

endmodule

`default_nettype wire

[rtl/sll_pool.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sll_pool: node pool storage
// Data and link memories, each with one write port and one registered read
// port. A read at the address written in the same cycle returns the old word.
// ----------------------------------------------------------------------------
module sll_pool (
  input  wire logic              clk,
  input  wire sll_pkg::mem_req_t req,
  output sll_pkg::word_t         data_rd,
  output sll_pkg::idx_t          link_rd
);

  sll_pkg::word_t data_mem [sll_pkg::NODES];
  sll_pkg::idx_t  link_mem [sll_pkg::NODES];

  always_ff @(posedge clk) begin
    if (req.data_we) begin
      data_mem[req.data_waddr] <= req.data_wdata;
    end
    if (req.data_re) begin
      data_rd <= data_mem[req.data_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.link_we) begin
      link_mem[req.link_waddr] <= req.link_wdata;
    end
    if (req.link_re) begin
      link_rd <= link_mem[req.link_raddr];
    end
  end

endmodule

`default_nettype wire
